FILE: sv/cbsf_pkg.sv
// Package for the byte stream filter: shared types, codes and character constants.
// Used by cbsf_front, cbsf_back and cat_byte_stream_filter_core; no dependencies.
package cbsf_pkg;

  // Sizing defaults
  localparam int unsigned NumberDigitsDef = 6;
  localparam int unsigned QueueDepthDef   = 2;

  // Configuration port
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUMBER_ALL       = 3'd0,
    CFG_NUMBER_NONBLANK  = 3'd1,
    CFG_SQUEEZE_BLANK    = 3'd2,
    CFG_SHOW_ENDS        = 3'd3,
    CFG_SHOW_TABS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // Characters
  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChTab     = 8'd9;
  localparam logic [7:0] ChSpace   = 8'd32;
  localparam logic [7:0] ChDollar  = 8'd36;
  localparam logic [7:0] ChCaret   = 8'd94;
  localparam logic [7:0] ChQuest   = 8'd63;
  localparam logic [7:0] ChBigM    = 8'd77;
  localparam logic [7:0] ChDash    = 8'd45;
  localparam logic [7:0] ChZero    = 8'd48;
  localparam logic [7:0] ChShownTab = 8'd73;  // tab plus 64, the letter I
  localparam logic [7:0] ChDel     = 8'd127;
  localparam logic [7:0] ChHighPrt = 8'd160;  // 128 + 32
  localparam logic [7:0] ChHighDel = 8'd255;  // 128 + 127
  localparam logic [7:0] ChHigh    = 8'd128;
  localparam logic [7:0] Ofs64     = 8'd64;

  // Classified item handed from front to back (line number digits travel beside it)
  typedef struct packed {
    logic            number;    // emit the line number field and a tab
    logic            dollar;    // emit a dollar sign
    logic            caret;     // emit the caret of a shown tab
    logic [1:0]      vis_last;  // index of the last rendered byte
    logic [3:0][7:0] vis;       // rendered bytes, entry 0 first
  } job_t;

  // Output sequencer phases
  typedef enum logic [4:0] {
    PH_NUM   = 5'b00001,
    PH_NTAB  = 5'b00010,
    PH_DOL   = 5'b00100,
    PH_CARET = 5'b01000,
    PH_VIS   = 5'b10000
  } phase_e;

endpackage

FILE: sv/cbsf_front.sv
// Front end of the byte stream filter: takes input words, keeps the line state
// and the BCD line counter, and classifies each byte into a job. Uses cbsf_pkg.
module cbsf_front #(
  parameter int unsigned NUMBER_DIGITS = cbsf_pkg::NumberDigitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cbsf_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   in_byte_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output cbsf_pkg::job_t               job_o,
  output logic [4*NUMBER_DIGITS-1:0]   digits_o
);

  localparam int unsigned CntW = 4 * NUMBER_DIGITS;

  logic [7:0]      prev_q, prev_d;
  logic            blank_q, blank_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic            accept, prev_nl, cur_nl, squeeze, number, caret;
  logic [7:0]      ch;

  // Saturating BCD increment
  always_comb begin
    logic all_nines;
    logic carry;
    logic [3:0] dig;
    all_nines = 1'b1;
    carry     = 1'b1;
    cnt_inc   = cnt_q;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (cnt_q[4*i +: 4] != 4'd9) all_nines = 1'b0;
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      dig = cnt_q[4*i +: 4];
      if (carry) begin
        if (dig == 4'd9) begin
          cnt_inc[4*i +: 4] = 4'd0;
        end else begin
          cnt_inc[4*i +: 4] = dig + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nines) cnt_inc = cnt_q;
  end

  // Classify the byte
  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign prev_nl    = (prev_q == cbsf_pkg::ChNewline);
  assign cur_nl     = (in_byte_i == cbsf_pkg::ChNewline);
  assign squeeze    = cfg_i.squeeze_blank && prev_nl && cur_nl && blank_q;
  assign number     = prev_nl && ((cfg_i.number_all && !cfg_i.number_nonblank) ||
                                  (cfg_i.number_nonblank && !cur_nl));
  assign caret      = cfg_i.show_tabs && (in_byte_i == cbsf_pkg::ChTab);
  assign ch         = caret ? cbsf_pkg::ChShownTab : in_byte_i;

  // Render the byte, with caret and M- forms when enabled
  always_comb begin
    job_o.number   = number;
    job_o.dollar   = cfg_i.show_ends && cur_nl;
    job_o.caret    = caret;
    job_o.vis      = '{default: 8'd0};
    job_o.vis[0]   = ch;
    job_o.vis_last = 2'd0;
    if (cfg_i.show_nonprinting && !(ch == cbsf_pkg::ChTab || ch == cbsf_pkg::ChNewline ||
        (ch >= cbsf_pkg::ChSpace && ch < cbsf_pkg::ChDel))) begin
      if (ch == cbsf_pkg::ChDel) begin
        job_o.vis[0]   = cbsf_pkg::ChCaret;
        job_o.vis[1]   = cbsf_pkg::ChQuest;
        job_o.vis_last = 2'd1;
      end else if (ch >= cbsf_pkg::ChHighPrt) begin
        job_o.vis[0] = cbsf_pkg::ChBigM;
        job_o.vis[1] = cbsf_pkg::ChDash;
        if (ch != cbsf_pkg::ChHighDel) begin
          job_o.vis[2]   = ch - cbsf_pkg::ChHigh;
          job_o.vis_last = 2'd2;
        end else begin
          job_o.vis[2]   = cbsf_pkg::ChCaret;
          job_o.vis[3]   = cbsf_pkg::ChQuest;
          job_o.vis_last = 2'd3;
        end
      end else if (ch >= cbsf_pkg::ChHigh) begin
        job_o.vis[0]   = cbsf_pkg::ChBigM;
        job_o.vis[1]   = cbsf_pkg::ChDash;
        job_o.vis[2]   = cbsf_pkg::ChCaret;
        job_o.vis[3]   = ch - cbsf_pkg::Ofs64;
        job_o.vis_last = 2'd3;
      end else begin
        job_o.vis[0]   = cbsf_pkg::ChCaret;
        job_o.vis[1]   = ch + cbsf_pkg::Ofs64;
        job_o.vis_last = 2'd1;
      end
    end
  end

  assign push_o   = accept && !squeeze;
  assign digits_o = number ? cnt_inc : cnt_q;

  // Advance the line state
  always_comb begin
    prev_d  = prev_q;
    blank_d = blank_q;
    cnt_d   = cnt_q;
    if (accept) begin
      if (squeeze) begin
        prev_d = cbsf_pkg::ChNewline;
      end else begin
        prev_d  = ch;
        blank_d = prev_nl && cur_nl;
        if (number) cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= cbsf_pkg::ChNewline;
      blank_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      prev_q  <= prev_d;
      blank_q <= blank_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: sv/cbsf_queue.sv
// Short register queue between the front and back of the byte stream filter.
// Generic width and depth; no package dependencies.
module cbsf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // Advance pointers with wrap at depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    if (pop_i)  rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

FILE: sv/cbsf_back.sv
// Back end of the byte stream filter: expands one queued job into output words,
// one per cycle when not stalled, via a registered output stage. Uses cbsf_pkg.
module cbsf_back #(
  parameter int unsigned NUMBER_DIGITS = cbsf_pkg::NumberDigitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  cbsf_pkg::job_t             head_job_i,
  input  logic [4*NUMBER_DIGITS-1:0] head_digits_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_last_o
);

  localparam int unsigned DigW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  logic                  mid_q, mid_d;
  cbsf_pkg::phase_e      phase_q, phase_d, phase, first_ph, after_ntab;
  logic [DigW-1:0]       dig_q, dig_d, dig;
  logic [1:0]            vis_q, vis_d, vis;
  logic                  started_q, started_d, started;
  logic                  emit, last;
  logic [7:0]            byte_c;
  logic [3:0]            digit;
  logic                  vld_q;
  logic [7:0]            byte_q;
  logic                  last_q;

  // Pick the current step: first step of the head job, or the one in progress
  always_comb begin
    if (head_job_i.number)      first_ph = cbsf_pkg::PH_NUM;
    else if (head_job_i.dollar) first_ph = cbsf_pkg::PH_DOL;
    else if (head_job_i.caret)  first_ph = cbsf_pkg::PH_CARET;
    else                        first_ph = cbsf_pkg::PH_VIS;
    if (head_job_i.dollar)      after_ntab = cbsf_pkg::PH_DOL;
    else if (head_job_i.caret)  after_ntab = cbsf_pkg::PH_CARET;
    else                        after_ntab = cbsf_pkg::PH_VIS;
  end

  assign phase   = mid_q ? phase_q : first_ph;
  assign dig     = mid_q ? dig_q : DigW'(NUMBER_DIGITS - 1);
  assign vis     = mid_q ? vis_q : 2'd0;
  assign started = mid_q ? started_q : 1'b0;
  assign digit   = head_digits_i[4*dig +: 4];
  assign emit    = head_valid_i && (!vld_q || out_ready_i);
  assign pop_o   = emit && last;

  // Produce the byte and the following step
  always_comb begin
    byte_c    = head_job_i.vis[vis];
    last      = 1'b0;
    phase_d   = phase;
    dig_d     = dig;
    vis_d     = vis;
    started_d = started;
    case (phase)
      cbsf_pkg::PH_NUM: begin
        if (!started && digit == 4'd0 && dig != '0) begin
          byte_c = cbsf_pkg::ChSpace;
        end else begin
          byte_c    = cbsf_pkg::ChZero + {4'd0, digit};
          started_d = 1'b1;
        end
        if (dig == '0) phase_d = cbsf_pkg::PH_NTAB;
        else           dig_d   = dig - DigW'(1);
      end
      cbsf_pkg::PH_NTAB: begin
        byte_c  = cbsf_pkg::ChTab;
        phase_d = after_ntab;
      end
      cbsf_pkg::PH_DOL: begin
        byte_c  = cbsf_pkg::ChDollar;
        phase_d = head_job_i.caret ? cbsf_pkg::PH_CARET : cbsf_pkg::PH_VIS;
      end
      cbsf_pkg::PH_CARET: begin
        byte_c  = cbsf_pkg::ChCaret;
        phase_d = cbsf_pkg::PH_VIS;
      end
      cbsf_pkg::PH_VIS: begin
        byte_c = head_job_i.vis[vis];
        last   = (vis == head_job_i.vis_last);
        vis_d  = vis + 2'd1;
      end
      default: begin
        byte_c = head_job_i.vis[vis];
        last   = 1'b1;
      end
    endcase
  end

  assign mid_d = emit ? !last : mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q     <= 1'b0;
      phase_q   <= cbsf_pkg::PH_VIS;
      dig_q     <= '0;
      vis_q     <= '0;
      started_q <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      mid_q <= mid_d;
      if (emit) begin
        phase_q   <= phase_d;
        dig_q     <= dig_d;
        vis_q     <= vis_d;
        started_q <= started_d;
      end
      if (emit)             vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_c;
      last_q <= last;
    end
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

FILE: sv/cat_byte_stream_filter_core.sv
// Top level of the byte stream filter: configuration registers, front end,
// job queue and output sequencer. Uses cbsf_pkg, cbsf_front, cbsf_queue, cbsf_back.
//
//   channel   direction  handshake               payload
//   s_axis    in         s_axis_tvalid/tready    tdata[7:0] in_byte
//   m_axis    out        m_axis_tvalid/tready    tdata[7:0] out_byte, tlast run_end
//   cfg       in         cfg_valid/cfg_ready     cfg_index[2:0], cfg_data[0]
//
// One output word leaves per cycle while tready is high; an input byte that expands to
// N words (1 to 11) occupies the output sequencer for all N, and single-word bytes flow
// back to back. The front end classifies a byte in the cycle it is taken; it stalls
// only while the job queue is full. A squeezed empty line is taken and yields no word.
// Reset clears the options, sets the previous byte to newline and the counter to zero.
// cfg_ready is always high; write registers only while the block is idle.
module cat_byte_stream_filter_core #(
  parameter int unsigned NUMBER_DIGITS = cbsf_pkg::NumberDigitsDef,
  parameter int unsigned QUEUE_DEPTH   = cbsf_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,   // [7:0] in_byte
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [7:0]                   m_axis_tdata_o,   // [7:0] out_byte
  output logic                         m_axis_tlast_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cbsf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic                         cfg_data_i
);

  localparam int unsigned CntW  = 4 * NUMBER_DIGITS;
  localparam int unsigned JobW  = $bits(cbsf_pkg::job_t) + CntW;

  cbsf_pkg::cfg_t       cfg_q, cfg_d;
  cbsf_pkg::job_t       f_job, h_job;
  logic [CntW-1:0]      f_digits, h_digits;
  logic                 push, pop, full, h_valid;
  logic [JobW-1:0]      q_wdata, q_rdata;

  // Write configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cbsf_pkg::cfg_idx_e'(cfg_index_i))
        cbsf_pkg::CFG_NUMBER_ALL:       cfg_d.number_all       = cfg_data_i;
        cbsf_pkg::CFG_NUMBER_NONBLANK:  cfg_d.number_nonblank  = cfg_data_i;
        cbsf_pkg::CFG_SQUEEZE_BLANK:    cfg_d.squeeze_blank    = cfg_data_i;
        cbsf_pkg::CFG_SHOW_ENDS:        cfg_d.show_ends        = cfg_data_i;
        cbsf_pkg::CFG_SHOW_TABS:        cfg_d.show_tabs        = cfg_data_i;
        cbsf_pkg::CFG_SHOW_NONPRINTING: cfg_d.show_nonprinting = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= '0;
    else         cfg_q <= cfg_d;
  end

  cbsf_front #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (f_job),
    .digits_o     (f_digits)
  );

  assign q_wdata  = {f_job, f_digits};
  assign h_job    = cbsf_pkg::job_t'(q_rdata[JobW-1:CntW]);
  assign h_digits = q_rdata[CntW-1:0];

  cbsf_queue #(
    .WIDTH (JobW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (h_valid),
    .data_o  (q_rdata)
  );

  cbsf_back #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (h_valid),
    .head_job_i    (h_job),
    .head_digits_i (h_digits),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_byte_o    (m_axis_tdata_o),
    .out_last_o    (m_axis_tlast_o)
  );

endmodule

FILE: tb/cat_byte_stream_filter_core_tb.sv
// Self-checking testbench for cat_byte_stream_filter_core: directed and random byte streams
// checked word by word against a local formatter model. Depends on cbsf_pkg and the core RTL.
module cat_byte_stream_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbsf_pkg::*;

  localparam int unsigned NDIG           = NumberDigitsDef;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned PHASE_BYTES    = 16;
  localparam int unsigned RANDOM_PHASES  = 6;

  // Register indexes past the last option; writes there must be dropped
  localparam logic [CfgIdxW-1:0] IdxPastLast = 3'd6;
  localparam logic [CfgIdxW-1:0] IdxTop      = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  // DUT connections
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i  = 8'd0;  // [7:0] in_byte
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [7:0]         m_axis_tdata_o;          // [7:0] out_byte
  logic               m_axis_tlast_o;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i     = '0;
  logic               cfg_data_i      = 1'b0;

  // Formatter model state
  cfg_t                  model_cfg   = '0;
  logic [7:0]            model_prev  = ChNewline;
  logic                  model_blank = 1'b0;
  logic [NDIG-1:0][3:0]  model_count = '0;

  out_word_t expected_words[$];
  out_word_t want;
  int        error_count   = 0;
  int        bytes_sent    = 0;
  int        words_checked = 0;
  int        cycle_count   = 0;
  int        sink_hold     = 0;
  bit        no_idle       = 1'b0;

  cat_byte_stream_filter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Format one accepted byte and queue the words it must produce
  function automatic void format_byte(input logic [7:0] in_b);
    logic [7:0] c;
    logic [7:0] words[$];
    logic       started;
    logic       full;
    logic       carry;
    c = in_b;
    // drop an empty line that follows an empty line
    if (model_cfg.squeeze_blank && model_prev == ChNewline && c == ChNewline && model_blank) begin
      model_prev = c;
      return;
    end
    model_blank = (model_prev == ChNewline && c == ChNewline);

    if (model_prev == ChNewline &&
        ((model_cfg.number_all && !model_cfg.number_nonblank) ||
         (model_cfg.number_nonblank && c != ChNewline))) begin
      // advance the BCD counter, holding at all nines
      full = 1'b1;
      for (int i = 0; i < NDIG; i++)
        if (model_count[i] != 4'd9) full = 1'b0;
      if (!full) begin
        carry = 1'b1;
        for (int i = 0; i < NDIG; i++) begin
          if (carry) begin
            if (model_count[i] < 4'd9) begin
              model_count[i] = model_count[i] + 4'd1;
              carry = 1'b0;
            end else begin
              model_count[i] = 4'd0;
            end
          end
        end
      end
      // right-aligned field, leading zeros as spaces, then a tab
      started = 1'b0;
      for (int i = NDIG - 1; i >= 0; i--) begin
        if (!started && model_count[i] == 4'd0 && i > 0) begin
          words.push_back(ChSpace);
        end else begin
          started = 1'b1;
          words.push_back(ChZero + 8'(model_count[i]));
        end
      end
      words.push_back(ChTab);
    end

    if (model_cfg.show_ends && c == ChNewline) words.push_back(ChDollar);
    if (model_cfg.show_tabs && c == ChTab) begin
      words.push_back(ChCaret);
      c = ChShownTab;
    end

    if (!model_cfg.show_nonprinting || c == ChTab || c == ChNewline ||
        (c >= ChSpace && c < ChDel)) begin
      words.push_back(c);
    end else if (c == ChDel) begin
      words.push_back(ChCaret);
      words.push_back(ChQuest);
    end else if (c >= ChHighPrt) begin
      words.push_back(ChBigM);
      words.push_back(ChDash);
      if (c < ChHighDel) begin
        words.push_back(c - ChHigh);
      end else begin
        words.push_back(ChCaret);
        words.push_back(ChQuest);
      end
    end else if (c >= ChHigh) begin
      words.push_back(ChBigM);
      words.push_back(ChDash);
      words.push_back(ChCaret);
      words.push_back(c - Ofs64);
    end else begin
      words.push_back(ChCaret);
      words.push_back(c + Ofs64);
    end

    model_prev = c;
    foreach (words[i]) expected_words.push_back('{data: words[i], last: (i == words.size() - 1)});
  endfunction

  // Text-like byte mix: many newlines and printables, some tabs, controls and high bytes
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return ChNewline;
    if (r < 40) return ChTab;
    if (r < 75) return 8'($urandom_range(32, 126));
    if (r < 85) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(127, 255));
  endfunction

  // Drive one byte; called and returns at a falling edge, tvalid left high
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    format_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input until every expected word is out, then let in-flight work settle
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write one register; cfg_valid is left high for back-to-back writes
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NUMBER_ALL:       model_cfg.number_all       = val;
      CFG_NUMBER_NONBLANK:  model_cfg.number_nonblank  = val;
      CFG_SQUEEZE_BLANK:    model_cfg.squeeze_blank    = val;
      CFG_SHOW_ENDS:        model_cfg.show_ends        = val;
      CFG_SHOW_TABS:        model_cfg.show_tabs        = val;
      CFG_SHOW_NONPRINTING: model_cfg.show_nonprinting = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_config(input cfg_t setting);
    wait_idle();
    write_reg(CFG_NUMBER_ALL,       setting.number_all);
    write_reg(CFG_NUMBER_NONBLANK,  setting.number_nonblank);
    write_reg(CFG_SQUEEZE_BLANK,    setting.squeeze_blank);
    write_reg(CFG_SHOW_ENDS,        setting.show_ends);
    write_reg(CFG_SHOW_TABS,        setting.show_tabs);
    write_reg(CFG_SHOW_NONPRINTING, setting.show_nonprinting);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset options: every byte passes through unchanged
  task automatic test_passthrough();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChTab);
    send_byte(ChNewline);
  endtask

  // Numbering of all lines with squeezing and line-end marks, then nonblank-only numbering
  task automatic test_numbering();
    cfg_t setting;
    setting = '0;
    setting.number_all    = 1'b1;
    setting.squeeze_blank = 1'b1;
    setting.show_ends     = 1'b1;
    apply_config(setting);
    send_byte("a");
    send_byte(ChNewline);
    send_byte(ChNewline);
    send_byte(ChNewline);
    send_byte(ChNewline);
    send_byte("b");
    send_byte(ChNewline);
    setting.number_nonblank = 1'b1;
    apply_config(setting);
    send_byte(ChNewline);
    send_byte("c");
    send_byte(ChNewline);
  endtask

  // Caret and M- forms at every class boundary; writes past the last register are dropped
  task automatic test_nonprinting();
    cfg_t setting;
    setting = '0;
    setting.show_tabs        = 1'b1;
    setting.show_nonprinting = 1'b1;
    apply_config(setting);
    write_reg(IdxPastLast, 1'b1);
    write_reg(IdxTop, 1'b1);
    cfg_valid_i <= 1'b0;
    send_byte(8'd0);
    send_byte(8'd31);
    send_byte(ChDel);
    send_byte(ChHigh);
    send_byte(8'd159);
    send_byte(ChHighPrt);
    send_byte(8'd254);
    send_byte(ChHighDel);
    send_byte(ChTab);
    send_byte(ChSpace);
    send_byte(8'd126);
  endtask

  // Random text under a series of option settings, extremes first
  task automatic test_random_text();
    cfg_t setting;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)      setting = '1;
      else if (p == 1) setting = '0;
      else             setting = 6'($urandom_range(0, 63));
      apply_config(setting);
      no_idle = (p == 2);
      for (int n = 0; n < PHASE_BYTES; n++) begin
        // pause mid-phase until the output has fully drained
        if (p == 3 && n == PHASE_BYTES / 2) wait_idle();
        send_byte(pick_text_byte());
      end
      no_idle = 1'b0;
    end
  endtask

  // Output ready: stall a random number of cycles after each word
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      m_axis_tready_i <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte %0h run_end %0b", m_axis_tdata_o, m_axis_tlast_o);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata_o !== want.data) begin
          $error("out_byte mismatch: expected %0h, actual %0h", want.data, m_axis_tdata_o);
          error_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("run_end mismatch: expected %0b, actual %0b", want.last, m_axis_tlast_o);
          error_count++;
        end
      end
      words_checked++;
      sink_hold = no_idle ? 0 : $urandom_range(0, 3);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_passthrough();
    test_numbering();
    test_nonprinting();
    test_random_text();
    wait_idle();
    // The counter saturates only after 999999 lines, far past this run length.
    $display("Sent %0d bytes under %0d random option settings; checked %0d output words.",
             bytes_sent, RANDOM_PHASES, words_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/cbsf_pkg.sv
sv/cbsf_front.sv
sv/cbsf_queue.sv
sv/cbsf_back.sv
sv/cat_byte_stream_filter_core.sv
tb/cat_byte_stream_filter_core_tb.sv
